// ----- rtl/core/pzs_pkg.sv -----
// package: shared types, constants and state codes for the z-score standardizer
`default_nettype none
package pzs_pkg;

    localparam int STORE_DEPTH_DEF = 1024;
    localparam int SAMPLE_W        = 16;
    localparam int VAL_W           = 16;
    localparam int IDXO_W          = 10;
    localparam int MEAN_W          = 24;
    localparam int SD_W            = 23;
    localparam int AD_W            = 23;
    localparam int VAR_W           = 2 * AD_W;
    localparam int NUM_W           = AD_W + 8;
    localparam int DVS_W           = 24;
    localparam int SQRT_STEPS      = VAR_W / 2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic                       func;
        logic signed [SAMPLE_W-1:0] sample_value;
    } in_beat_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] standardized_value;
        logic [IDXO_W-1:0]       sample_index;
        logic                    last_sample;
        logic                    stats_error;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_DIV,
        ST_PASS_ADDR,
        ST_PASS_MUL,
        ST_PASS_ACC,
        ST_VAR_GO,
        ST_VAR_DIV,
        ST_SQRT,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_OUT_DIV,
        ST_FINISH
    } pzs_state_t;

    typedef struct packed {
        logic load;
        logic stats_zero;
        logic mean_start;
        logic mean_take;
        logic pass_clear;
        logic pass_sel;
        logic pass_mul;
        logic pass_acc;
        logic var_start;
        logic sqrt_start;
        logic sqrt_step;
        logic stats_set;
        logic rd_capture;
        logic out_start;
        logic out_load;
    } pzs_cmd_t;

    typedef struct packed {
        logic loaded_zero;
        logic full;
        logic pos_zero;
        logic stats_ready;
        logic pass_last;
        logic need_div;
        logic div_done;
        logic sqrt_last;
        logic out_free;
    } pzs_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/pzs_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none
module pzs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/pzs_div.sv -----
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module pzs_div #(
    parameter int DIV_W = 57,
    parameter int DVS_W = 24
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [DIV_W-1:0]           dividend,
    input  wire logic [DVS_W-1:0]           divisor,
    input  wire logic [$clog2(DIV_W+1)-1:0] nbits,
    output logic                            done,
    output logic      [DIV_W-1:0]           quotient
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DVS_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = shifted >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ----- rtl/core/pzs_dp.sv -----
// datapath: sample store, accumulators, divider, square root and output register
`default_nettype none
module pzs_dp #(
    parameter int STORE_DEPTH = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire pzs_pkg::pzs_cmd_t                     cmd,
    output pzs_pkg::pzs_status_t                       status,
    input  wire logic signed [pzs_pkg::SAMPLE_W-1:0]   sample_value,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output pzs_pkg::out_beat_t                         out_data
);
    import pzs_pkg::*;

    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int SUM_W  = SAMPLE_W - 1 + CNT_W;
    localparam int DIV_W  = VAR_W + CNT_W;
    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam int SQC_W  = $clog2(SQRT_STEPS + 1);

    logic [CNT_W-1:0]      loaded_reg;
    logic [CNT_W-1:0]      pos_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [MEAN_W-1:0]     mean_reg;
    logic [IDX_W-1:0]      rd_ptr_reg;
    logic [IDX_W-1:0]      pass_ptr_reg;
    logic                  stats_ready_reg;
    logic [VAR_W-1:0]      prod_reg;
    logic [DIV_W-1:0]      sq_reg;
    logic [VAR_W-1:0]      v_reg;
    logic [VAR_W-1:0]      root_reg;
    logic [VAR_W-1:0]      bit_reg;
    logic [SQC_W-1:0]      scnt_reg;
    logic                  neg_reg;
    logic                  need_div_reg;
    logic                  err_reg;
    logic                  out_valid_reg;
    out_beat_t             out_data_reg;

    logic [SAMPLE_W-1:0]   rdata;
    logic [IDX_W-1:0]      raddr;
    logic                  x_pos;
    logic signed [MEAN_W:0] d;
    logic [MEAN_W:0]       ad_full;
    logic [AD_W-1:0]       ad;
    logic [SD_W-1:0]       sd;
    logic                  err;
    logic                  div_start;
    logic [DIV_W-1:0]      dividend;
    logic [DVS_W-1:0]      divisor;
    logic [DCNT_W-1:0]     nbits;
    logic                  div_done;
    logic [DIV_W-1:0]      quotient;
    logic [VAR_W-1:0]      trial;
    logic [CNT_W-1:0]      pass_ptr_inc;
    logic [CNT_W-1:0]      rd_ptr_inc;
    logic                  is_last;
    logic [NUM_W-1:0]      q;
    logic [VAL_W-1:0]      value;
    logic [IDX_W+IDXO_W-1:0] idx_ext;

    assign raddr = cmd.pass_sel ? pass_ptr_reg : rd_ptr_reg;

    pzs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (loaded_reg[IDX_W-1:0]),
        .wdata (sample_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        x_pos   = !rdata[SAMPLE_W-1] && (rdata != '0);
        d       = $signed({rdata[SAMPLE_W-1], rdata, 8'b0}) - $signed({1'b0, mean_reg});
        ad_full = d[MEAN_W] ? (MEAN_W + 1)'(0) - d : d;
        ad      = ad_full[AD_W-1:0];
        sd      = root_reg[SD_W-1:0];
        err     = (pos_reg == '0) || (sd == '0);
        trial   = root_reg + bit_reg;
    end

    // one divider serves the mean, the variance and every output value that needs a divide
    always_comb
    begin
        div_start = cmd.mean_start || cmd.var_start || cmd.out_start;
        if (cmd.mean_start)
        begin
            dividend = {sum_reg, 8'b0, {(DIV_W - SUM_W - 8){1'b0}}};
            divisor  = DVS_W'(pos_reg);
            nbits    = DCNT_W'(SUM_W + 8);
        end
        else if (cmd.var_start)
        begin
            dividend = sq_reg;
            divisor  = DVS_W'(pos_reg);
            nbits    = DCNT_W'(DIV_W);
        end
        else
        begin
            dividend = {ad, 8'b0, {(DIV_W - NUM_W){1'b0}}};
            divisor  = DVS_W'(sd);
            nbits    = DCNT_W'(NUM_W);
        end
    end

    pzs_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .nbits    (nbits),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        pass_ptr_inc = CNT_W'(pass_ptr_reg) + CNT_W'(1);
        rd_ptr_inc   = CNT_W'(rd_ptr_reg) + CNT_W'(1);
        is_last      = rd_ptr_inc == loaded_reg;
        q            = quotient[NUM_W-1:0];
        idx_ext      = {{IDXO_W{1'b0}}, rd_ptr_reg};
        // truncate toward zero, then saturate to q8.8
        if (!need_div_reg)
        begin
            value = '0;
        end
        else if (!neg_reg)
        begin
            value = (q > NUM_W'(32767)) ? VAL_W'(32767) : q[VAL_W-1:0];
        end
        else
        begin
            value = (q > NUM_W'(32768)) ? VAL_W'(32768) : VAL_W'(0) - q[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg      <= '0;
            pos_reg         <= '0;
            sum_reg         <= '0;
            mean_reg        <= '0;
            rd_ptr_reg      <= '0;
            pass_ptr_reg    <= '0;
            stats_ready_reg <= 1'b0;
            root_reg        <= '0;
            scnt_reg        <= '0;
            need_div_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                loaded_reg <= loaded_reg + CNT_W'(1);
                if (!sample_value[SAMPLE_W-1] && (sample_value != '0))
                begin
                    pos_reg <= pos_reg + CNT_W'(1);
                    sum_reg <= sum_reg + SUM_W'(sample_value[SAMPLE_W-2:0]);
                end
            end
            if (cmd.stats_zero)
            begin
                mean_reg        <= '0;
                root_reg        <= '0;
                stats_ready_reg <= 1'b1;
            end
            if (cmd.mean_take)
            begin
                mean_reg <= quotient[MEAN_W-1:0];
            end
            if (cmd.pass_clear)
            begin
                pass_ptr_reg <= '0;
            end
            if (cmd.pass_acc)
            begin
                pass_ptr_reg <= pass_ptr_reg + IDX_W'(1);
            end
            if (cmd.sqrt_start)
            begin
                root_reg <= '0;
                scnt_reg <= SQC_W'(SQRT_STEPS);
            end
            if (cmd.sqrt_step)
            begin
                scnt_reg <= scnt_reg - SQC_W'(1);
                if (v_reg >= trial)
                begin
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
            end
            if (cmd.stats_set)
            begin
                stats_ready_reg <= 1'b1;
            end
            if (cmd.rd_capture)
            begin
                need_div_reg <= !err && x_pos;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                if (is_last)
                begin
                    loaded_reg      <= '0;
                    pos_reg         <= '0;
                    sum_reg         <= '0;
                    mean_reg        <= '0;
                    root_reg        <= '0;
                    rd_ptr_reg      <= '0;
                    stats_ready_reg <= 1'b0;
                end
                else
                begin
                    rd_ptr_reg <= rd_ptr_reg + IDX_W'(1);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pass_mul)
        begin
            prod_reg <= x_pos ? VAR_W'(ad * ad) : '0;
        end
        if (cmd.pass_clear)
        begin
            sq_reg <= '0;
        end
        else if (cmd.pass_acc)
        begin
            sq_reg <= sq_reg + DIV_W'(prod_reg);
        end
        if (cmd.sqrt_start)
        begin
            v_reg   <= quotient[VAR_W-1:0];
            bit_reg <= VAR_W'(1) << (VAR_W - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.rd_capture)
        begin
            neg_reg <= d[MEAN_W];
            err_reg <= err;
        end
        if (cmd.out_load)
        begin
            out_data_reg.standardized_value <= value;
            out_data_reg.sample_index       <= idx_ext[IDXO_W-1:0];
            out_data_reg.last_sample        <= is_last;
            out_data_reg.stats_error        <= err_reg;
        end
    end

    always_comb
    begin
        status.loaded_zero = loaded_reg == '0;
        status.full        = loaded_reg == CNT_W'(STORE_DEPTH);
        status.pos_zero    = pos_reg == '0;
        status.stats_ready = stats_ready_reg;
        status.pass_last   = pass_ptr_inc == loaded_reg;
        status.need_div    = !err && x_pos;
        status.div_done    = div_done;
        status.sqrt_last   = scnt_reg == SQC_W'(1);
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        stats_ready_reg |-> (CNT_W'(rd_ptr_reg) < loaded_reg))
        else $error("read-out pointer beyond loaded samples");
    a_sum_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == '0) |-> (sum_reg == '0))
        else $error("positive sum without positive samples");
    a_pos_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= loaded_reg)
        else $error("positive count exceeds loaded count");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/pzs_ctrl.sv -----
// controller: sequences loads, statistics pass and per-sample read-out
`default_nettype none
module pzs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_func,
    output logic                      in_ready,
    input  wire pzs_pkg::pzs_status_t status,
    output pzs_pkg::pzs_cmd_t         cmd
);
    import pzs_pkg::*;

    pzs_state_t state_reg;
    pzs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func == FUNC_LOAD)
                    begin
                        cmd.load = !status.stats_ready && !status.full;
                    end
                    else if (!status.loaded_zero)
                    begin
                        if (status.stats_ready)
                        begin
                            state_next = ST_RD_ADDR;
                        end
                        else if (status.pos_zero)
                        begin
                            cmd.stats_zero = 1'b1;
                            state_next     = ST_RD_ADDR;
                        end
                        else
                        begin
                            cmd.mean_start = 1'b1;
                            state_next     = ST_MEAN_DIV;
                        end
                    end
                end
            end
            ST_MEAN_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.mean_take  = 1'b1;
                    cmd.pass_clear = 1'b1;
                    state_next     = ST_PASS_ADDR;
                end
            end
            ST_PASS_ADDR:
            begin
                cmd.pass_sel = 1'b1;
                state_next   = ST_PASS_MUL;
            end
            ST_PASS_MUL:
            begin
                cmd.pass_mul = 1'b1;
                state_next   = ST_PASS_ACC;
            end
            ST_PASS_ACC:
            begin
                cmd.pass_acc = 1'b1;
                state_next   = status.pass_last ? ST_VAR_GO : ST_PASS_ADDR;
            end
            ST_VAR_GO:
            begin
                cmd.var_start = 1'b1;
                state_next    = ST_VAR_DIV;
            end
            ST_VAR_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last)
                begin
                    cmd.stats_set = 1'b1;
                    state_next    = ST_RD_ADDR;
                end
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                cmd.rd_capture = 1'b1;
                if (status.need_div)
                begin
                    cmd.out_start = 1'b1;
                    state_next    = ST_OUT_DIV;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_OUT_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ST_MEAN_DIV || state_reg == ST_VAR_DIV
                             || state_reg == ST_OUT_DIV))
        else $error("divider finished outside a divide wait");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/positive_sample_zscore_standardizer.sv -----
// Positive-sample z-score standardizer: loads samples, then streams them out standardized.
// Input channel in_valid/in_ready/in_data: func 0 loads one sample into the store (no result;
// ignored when the store is full or a read-out is in progress);
// func 1 asks for the next standardized sample in load order (ignored when empty).
// Output channel out_valid/out_ready/out_data carries one beat per read-out request.
// A read-out runs the 31-step serial divide of the output value;
// a non-positive sample or an error beat skips the divide.
// The first read-out after loading also runs the statistics: a serial mean divide
// (SUM_W+8 steps), a memory pass over every loaded sample through the single
// store read port, a variance divide (46+CNT_W steps) and a 23-step square root.
// The result sits in an output register; the next item is accepted while it waits,
// and a stalled receiver holds the following result in the datapath until taken.
// Reset clears counts, statistics and pointers; the store contents are not cleared
// and entries are only read after they are written. After the last sample is returned
// the block is empty again and ready for a new load sequence.
`default_nettype none
module positive_sample_zscore_standardizer #(
    parameter int STORE_DEPTH = pzs_pkg::STORE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pzs_pkg::in_beat_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pzs_pkg::out_beat_t      out_data
);
    import pzs_pkg::*;

    pzs_cmd_t    cmd;
    pzs_status_t status;

    pzs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (in_data.func),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pzs_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_value (in_data.sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for the positive-sample z-score standardizer: directed and random load/read-out sets
`default_nettype none
module testbench;
    import pzs_pkg::*;

    localparam int DEPTH = 1024;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_beat_t out_data;

    positive_sample_zscore_standardizer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #5 clk = ~clk;

    in_beat_t pending_beats[$];
    out_beat_t expected_results[$];
    int mismatches = 0;
    int accepted = 0;
    longint cycles = 0;

    // shadow copy of the block state
    logic signed [SAMPLE_W-1:0] shadow_store[DEPTH];
    int unsigned n_loaded = 0;
    int unsigned n_positive = 0;
    longint pos_sum = 0;
    longint mean_q8 = 0;
    longint sd_q8 = 0;
    int unsigned read_ptr = 0;
    bit have_stats = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    task automatic standardize(input in_beat_t beat);
        longint x;
        longint d;
        longint val;
        longint unsigned sq;
        out_beat_t res;
        bit err;
        if (beat.func == FUNC_LOAD)
        begin
            if (have_stats || n_loaded >= DEPTH)
                return;
            shadow_store[n_loaded] = beat.sample_value;
            n_loaded++;
            x = beat.sample_value;
            if (x > 0)
            begin
                n_positive++;
                pos_sum += x;
            end
            return;
        end
        if (n_loaded == 0)
            return;
        if (!have_stats)
        begin
            mean_q8 = 0;
            sd_q8 = 0;
            sq = 0;
            if (n_positive != 0)
            begin
                mean_q8 = (pos_sum * 256) / n_positive;
                for (int i = 0; i < n_loaded; i++)
                begin
                    x = shadow_store[i];
                    if (x > 0)
                    begin
                        d = x * 256 - mean_q8;
                        if (d < 0)
                            d = -d;
                        sq += d * d;
                    end
                end
                sd_q8 = int_sqrt(sq / n_positive);
            end
            have_stats = 1'b1;
        end
        err = (n_positive == 0) || (sd_q8 == 0);
        x = shadow_store[read_ptr];
        val = 0;
        if (!err && x > 0)
        begin
            d = x * 256 - mean_q8;
            val = (d * 256) / sd_q8;
            if (val > 32767)
                val = 32767;
            if (val < -32768)
                val = -32768;
        end
        res.standardized_value = val[VAL_W-1:0];
        res.sample_index = read_ptr[IDXO_W-1:0];
        res.last_sample = (read_ptr + 1 >= n_loaded);
        res.stats_error = err;
        expected_results.push_back(res);
        if (res.last_sample)
        begin
            n_loaded = 0;
            n_positive = 0;
            pos_sum = 0;
            mean_q8 = 0;
            sd_q8 = 0;
            read_ptr = 0;
            have_stats = 1'b0;
        end
        else
            read_ptr++;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // idle phases by accepted count: none, sender 61, receiver 61, both 16
    function automatic bit idle_now(input bit sender);
        int ph;
        ph = (accepted / 150) % 4;
        case (ph)
            1: return sender && ($urandom_range(0, 99) < 61);
            2: return !sender && ($urandom_range(0, 99) < 61);
            3: return $urandom_range(0, 99) < 16;
            default: return 1'b0;
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && in_valid && in_ready)
        begin
            standardize(in_data);
            accepted++;
        end
        if (!in_valid || in_ready)
        begin
            if (rst_n && pending_beats.size() > 0 && !idle_now(1'b1))
            begin
                in_data <= pending_beats.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected beat index", out_data.sample_index, -1);
            else
            begin
                want = expected_results.pop_front();
                if (out_data.standardized_value != want.standardized_value)
                    report_mismatch("standardized_value", out_data.standardized_value,
                                    want.standardized_value);
                if (out_data.sample_index != want.sample_index)
                    report_mismatch("sample_index", out_data.sample_index, want.sample_index);
                if (out_data.last_sample != want.last_sample)
                    report_mismatch("last_sample", out_data.last_sample, want.last_sample);
                if (out_data.stats_error != want.stats_error)
                    report_mismatch("stats_error", out_data.stats_error, want.stats_error);
            end
        end
        out_ready <= rst_n && !idle_now(1'b0);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_beat(input logic f, input logic signed [SAMPLE_W-1:0] v);
        in_beat_t b;
        b.func = f;
        b.sample_value = v;
        pending_beats.push_back(b);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int kind);
        case (kind)
            0: return SAMPLE_W'($urandom_range(0, 65535));
            1: return SAMPLE_W'($urandom_range(1, 300));
            2: return SAMPLE_W'(-$signed($urandom_range(0, 32768)));
            3: return $urandom_range(0, 3) == 0 ? 16'sd32767
                                                : SAMPLE_W'($urandom_range(1, 4));
            default: return SAMPLE_W'($urandom_range(0, 9) - 3);
        endcase
    endfunction

    // one load set followed by its read-out, with some stray loads and a stray read mixed in
    task automatic sample_set(input int n, input int kind, input bit noisy);
        for (int i = 0; i < n; i++)
            push_beat(FUNC_LOAD, pick_sample(kind));
        for (int i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
                push_beat(FUNC_LOAD, pick_sample(0));
            push_beat(FUNC_READ, SAMPLE_W'($urandom_range(0, 65535)));
        end
        if (noisy && $urandom_range(0, 3) == 0)
            push_beat(FUNC_READ, SAMPLE_W'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        int n;
        // directed: empty read, extremes, stray load during read-out
        push_beat(FUNC_READ, 16'sd0);
        push_beat(FUNC_LOAD, 16'sd32767);
        push_beat(FUNC_LOAD, -16'sd32768);
        push_beat(FUNC_LOAD, 16'sd0);
        push_beat(FUNC_LOAD, 16'sd1);
        push_beat(FUNC_READ, -16'sd1);
        push_beat(FUNC_LOAD, 16'sd77);
        push_beat(FUNC_READ, 16'sd0);
        push_beat(FUNC_READ, 16'sd0);
        push_beat(FUNC_READ, 16'sd0);
        push_beat(FUNC_READ, 16'sd0);
        // no positive sample
        push_beat(FUNC_LOAD, -16'sd5);
        push_beat(FUNC_LOAD, 16'sd0);
        push_beat(FUNC_READ, 16'sd0);
        push_beat(FUNC_READ, 16'sd0);
        // zero deviation: equal positives, then a lone positive
        push_beat(FUNC_LOAD, 16'sd9);
        push_beat(FUNC_LOAD, 16'sd9);
        push_beat(FUNC_LOAD, -16'sd3);
        push_beat(FUNC_READ, 16'sd0);
        push_beat(FUNC_READ, 16'sd0);
        push_beat(FUNC_READ, 16'sd0);
        push_beat(FUNC_LOAD, 16'sd1234);
        push_beat(FUNC_READ, 16'sd0);

        while (pending_beats.size() < 750)
        begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 100) : $urandom_range(1, 16);
            sample_set(n, $urandom_range(0, 4), $urandom_range(0, 4) == 0);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_beats.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
